>>> rtl/register_file_alu_8xyn_macros.svh
// Assertion macros shared by the register file ALU checker.
`ifndef REGISTER_FILE_ALU_8XYN_MACROS_SVH
`define REGISTER_FILE_ALU_8XYN_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RFA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check an implication on every rising clock edge outside reset.
`define RFA_ASSERT_IMPL(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

`endif

>>> rtl/rfa_pkg.sv
// Shared types and codes of the register file ALU.
package rfa_pkg;

   localparam int unsigned REG_COUNT = 16;
   localparam int unsigned ADDR_W    = 4;
   localparam int unsigned DATA_W    = 8;

   localparam logic [ADDR_W-1:0] FLAG_REG = 4'hf;

   // Item modes
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_EXEC  = 2'd2;

   // ALU operation codes (low nibble of 8xyn)
   localparam logic [3:0] OP_MOV  = 4'h0;
   localparam logic [3:0] OP_OR   = 4'h1;
   localparam logic [3:0] OP_AND  = 4'h2;
   localparam logic [3:0] OP_XOR  = 4'h3;
   localparam logic [3:0] OP_ADD  = 4'h4;
   localparam logic [3:0] OP_SUB  = 4'h5;
   localparam logic [3:0] OP_SHR  = 4'h6;
   localparam logic [3:0] OP_SUBN = 4'h7;
   localparam logic [3:0] OP_SHL  = 4'he;

   typedef struct packed {
      logic [1:0]        mode;
      logic [ADDR_W-1:0] reg_x;
      logic [ADDR_W-1:0] reg_y;
      logic [3:0]        alu_op;
      logic [DATA_W-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] x_value;
      logic [DATA_W-1:0] flag_value;
      logic              op_known;
   } rsp_type;

   typedef struct packed {
      logic [DATA_W-1:0] res;
      logic [DATA_W-1:0] flag;
      logic              writes_flag;
      logic              known;
   } alu_out_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } mem_wr_type;

endpackage

>>> rtl/rfa_regmem.sv
// Register storage: one write port, two registered read ports, reset-cleared valid bits.
module rfa_regmem
   import rfa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_a_addr,
   input  logic [ADDR_W-1:0] rd_b_addr,
   output logic [DATA_W-1:0] rd_a_data,
   output logic [DATA_W-1:0] rd_b_data,
   input  mem_wr_type        wr
);

   logic [DATA_W-1:0]    mem [REG_COUNT];
   logic [REG_COUNT-1:0] vld_ff;
   logic [REG_COUNT-1:0] vld_in;
   logic [DATA_W-1:0]    a_data_ff;
   logic [DATA_W-1:0]    b_data_ff;
   logic                 a_vld_ff;
   logic                 b_vld_ff;

   // Mark an entry valid once written
   always_comb begin
      vld_in = vld_ff;
      if (wr.en) begin
         vld_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Write the array
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read both ports, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         a_data_ff <= mem[rd_a_addr];
         b_data_ff <= mem[rd_b_addr];
         a_vld_ff  <= vld_ff[rd_a_addr];
         b_vld_ff  <= vld_ff[rd_b_addr];
      end
   end

   // Unwritten entries read as zero
   assign rd_a_data = a_vld_ff ? a_data_ff : '0;
   assign rd_b_data = b_vld_ff ? b_data_ff : '0;

endmodule

>>> rtl/rfa_alu.sv
// 8xyn ALU: result byte, flag byte and decode of the operation code.
module rfa_alu
   import rfa_pkg::*;
(
   input  logic [3:0]        alu_op,
   input  logic [DATA_W-1:0] vx,
   input  logic [DATA_W-1:0] vy,
   output alu_out_type       alu_out
);

   logic [DATA_W:0] sum;

   assign sum = {1'b0, vx} + {1'b0, vy};

   // Decode the operation and form result and flag
   always_comb begin
      alu_out             = '0;
      alu_out.known       = 1'b1;
      alu_out.writes_flag = 1'b1;
      unique case (alu_op)
         OP_MOV: begin
            alu_out.res         = vy;
            alu_out.writes_flag = 1'b0;
         end
         OP_OR:  alu_out.res = vx | vy;
         OP_AND: alu_out.res = vx & vy;
         OP_XOR: alu_out.res = vx ^ vy;
         OP_ADD: begin
            alu_out.res  = sum[DATA_W-1:0];
            alu_out.flag = {{(DATA_W-1){1'b0}}, sum[DATA_W]};
         end
         OP_SUB: begin
            alu_out.res  = vx - vy;
            alu_out.flag = {{(DATA_W-1){1'b0}}, (vx >= vy)};
         end
         OP_SHR: begin
            alu_out.res  = {1'b0, vy[DATA_W-1:1]};
            alu_out.flag = {{(DATA_W-1){1'b0}}, vy[0]};
         end
         OP_SUBN: begin
            alu_out.res  = vy - vx;
            alu_out.flag = {{(DATA_W-1){1'b0}}, (vy >= vx)};
         end
         OP_SHL: begin
            alu_out.res  = {vy[DATA_W-2:0], 1'b0};
            alu_out.flag = {{(DATA_W-1){1'b0}}, vy[DATA_W-1]};
         end
         default: begin
            alu_out.known       = 1'b0;
            alu_out.writes_flag = 1'b0;
         end
      endcase
   end

endmodule

>>> rtl/register_file_alu_8xyn.sv
// Top level of the sixteen-register file with the 8xyn ALU.
// For each word, the accept edge reads registers x and y from the
// synchronous register memory, and the execute state runs the ALU, writes back
// and loads the result register. The block takes the next word in the cycle after a
// result is loaded, even while that result still waits; it holds in the execute
// cycle only when a previous result has not yet been taken. Register 15 (the flag)
// lives in its own flop so a result and a flag can be written in the same cycle.
// Reset clears all registers at once through per-entry valid bits; no clearing pass.
module register_file_alu_8xyn
   import rfa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic              state_ff, state_in;
   req_type           req_ff;
   logic [DATA_W-1:0] flag_ff, flag_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;
   logic [DATA_W-1:0] mem_x, mem_y;
   logic [DATA_W-1:0] vx, vy;
   alu_out_type       alu_out;
   mem_wr_type        mem_wr;
   logic              accept, finish, exec_known, x_write;
   logic [DATA_W-1:0] x_data, x_new;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign finish    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   rfa_regmem u_mem (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_a_addr (req_data.reg_x),
      .rd_b_addr (req_data.reg_y),
      .rd_a_data (mem_x),
      .rd_b_data (mem_y),
      .wr        (mem_wr)
   );

   // Take register 15 from the flag flop
   assign vx = (req_ff.reg_x == FLAG_REG) ? flag_ff : mem_x;
   assign vy = (req_ff.reg_y == FLAG_REG) ? flag_ff : mem_y;

   rfa_alu u_alu (
      .alu_op  (req_ff.alu_op),
      .vx      (vx),
      .vy      (vy),
      .alu_out (alu_out)
   );

   // Write register x first, then the flag
   always_comb begin
      exec_known = (req_ff.mode == MODE_EXEC) && alu_out.known;
      x_write    = (req_ff.mode == MODE_WRITE) || exec_known;
      x_data     = (req_ff.mode == MODE_WRITE) ? req_ff.write_data : alu_out.res;
      flag_in    = flag_ff;
      if (exec_known && alu_out.writes_flag) begin
         flag_in = alu_out.flag;
      end else if (x_write && (req_ff.reg_x == FLAG_REG)) begin
         flag_in = x_data;
      end
      if (req_ff.reg_x == FLAG_REG) begin
         x_new = flag_in;
      end else begin
         x_new = x_write ? x_data : vx;
      end
      mem_wr.en   = finish && x_write && (req_ff.reg_x != FLAG_REG);
      mem_wr.addr = req_ff.reg_x;
      mem_wr.data = x_data;
   end

   // Sequence accept and execute
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Load or drop the result word
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         flag_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish) begin
            flag_ff <= flag_in;
         end
      end
   end

   // Hold the request and the result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (finish) begin
         rsp_ff.x_value    <= x_new;
         rsp_ff.flag_value <= flag_in;
         rsp_ff.op_known   <= exec_known;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/rfa_checker.sv
// Port checker for the register file ALU, bound to the top level.
`include "register_file_alu_8xyn_macros.svh"

module rfa_checker
   import rfa_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled result word holds
   `RFA_ASSERT_IMPL(a_rsp_hold, rsp_valid && !rsp_ready, ##1 (rsp_valid && $stable(rsp_data)), "result word changed while stalled")

   // Only one word in flight: no accept right after an accept
   `RFA_ASSERT_IMPL(a_one_in_flight, req_valid && req_ready, ##1 !req_ready, "word accepted while another executes")

   // A new result appears only after an execute cycle
   `RFA_ASSERT_IMPL(a_rsp_after_exec, $rose(rsp_valid), !$past(req_ready), "result without execute cycle")

   // No result right out of reset
   `RFA_ASSERT_IMPL(a_reset_empty, $past(reset), !rsp_valid, "result valid after reset")

endmodule

bind register_file_alu_8xyn rfa_checker u_rfa_checker (.*);

>>> tb/tb.sv
// Self-checking testbench for the register file with the 8xyn ALU.
`timescale 1ns / 1ps

module tb;
   import rfa_pkg::*;

   localparam int unsigned RANDOM_WORDS = 1200;
   localparam int unsigned CALM_WORDS   = 150;
   localparam int unsigned CYCLE_LIMIT  = 200000;

   // Track the register contents and the results still owed by the block.
   class alu_reg_tracker;
      logic [DATA_W-1:0] regs [REG_COUNT];
      rsp_type           owed [$];
      int unsigned       errors;

      function new();
         foreach (regs[i]) regs[i] = '0;
         errors = 0;
      endfunction

      // Advance the register copy by one accepted word and queue its result.
      function void apply_word(req_type w);
         logic [DATA_W-1:0] vx;
         logic [DATA_W-1:0] vy;
         logic [DATA_W-1:0] res;
         logic [DATA_W-1:0] flag;
         logic [DATA_W:0]   sum;
         logic              known;
         logic              writes_flag;
         rsp_type           due;
         vx = regs[w.reg_x];
         vy = regs[w.reg_y];
         res = '0;
         flag = '0;
         known = 1'b0;
         writes_flag = 1'b1;
         case (w.mode)
            MODE_WRITE: regs[w.reg_x] = w.write_data;
            MODE_EXEC: begin
               known = 1'b1;
               case (w.alu_op)
                  OP_MOV: begin
                     res = vy;
                     writes_flag = 1'b0;
                  end
                  OP_OR:  res = vx | vy;
                  OP_AND: res = vx & vy;
                  OP_XOR: res = vx ^ vy;
                  OP_ADD: begin
                     sum = {1'b0, vx} + {1'b0, vy};
                     res = sum[DATA_W-1:0];
                     flag = {7'd0, sum[DATA_W]};
                  end
                  OP_SUB: begin
                     res = vx - vy;
                     flag = {7'd0, vx >= vy};
                  end
                  OP_SHR: begin
                     res = vy >> 1;
                     flag = {7'd0, vy[0]};
                  end
                  OP_SUBN: begin
                     res = vy - vx;
                     flag = {7'd0, vy >= vx};
                  end
                  OP_SHL: begin
                     res = {vy[DATA_W-2:0], 1'b0};
                     flag = {7'd0, vy[DATA_W-1]};
                  end
                  default: known = 1'b0;
               endcase
               // Result first, then the flag, so the flag wins on register 15.
               if (known) begin
                  regs[w.reg_x] = res;
                  if (writes_flag) regs[FLAG_REG] = flag;
               end
            end
            default: ;
         endcase
         due.x_value = regs[w.reg_x];
         due.flag_value = regs[FLAG_REG];
         due.op_known = known;
         owed.push_back(due);
      endfunction

      // Compare one accepted result with the oldest owed result.
      function void check_word(rsp_type got);
         rsp_type due;
         if (owed.size() == 0) begin
            $error("unexpected result word: x_value %0h flag_value %0h op_known %0b",
                   got.x_value, got.flag_value, got.op_known);
            errors++;
         end else begin
            due = owed.pop_front();
            if (got.x_value !== due.x_value) begin
               $error("x_value: expected %0h, actual %0h", due.x_value, got.x_value);
               errors++;
            end
            if (got.flag_value !== due.flag_value) begin
               $error("flag_value: expected %0h, actual %0h", due.flag_value, got.flag_value);
               errors++;
            end
            if (got.op_known !== due.op_known) begin
               $error("op_known: expected %0b, actual %0b", due.op_known, got.op_known);
               errors++;
            end
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   alu_reg_tracker tracker;
   logic           calm = 1'b0;
   int unsigned    stall_left = 0;
   int unsigned    cycles = 0;

   register_file_alu_8xyn i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Run a 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Stall the result side in random bursts; drop stalls in the calm tail.
   always @(posedge clock) begin
      if (calm) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Check every result word taken from the block.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_word(rsp_data);
   end

   // Give up on a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic req_type make_word(logic [1:0] mode, logic [3:0] x, logic [3:0] y,
                                         logic [3:0] op, logic [7:0] data);
      req_type w;
      w.mode = mode;
      w.reg_x = x;
      w.reg_y = y;
      w.alu_op = op;
      w.write_data = data;
      return w;
   endfunction

   // Offer one word, with a random gap ahead of it outside the calm tail.
   task automatic send_word(req_type w);
      int unsigned gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.apply_word(w);
   endtask

   function automatic logic [7:0] pick_byte();
      logic [7:0] corners [5];
      corners = '{8'h00, 8'hff, 8'h80, 8'h7f, 8'h01};
      if ($urandom_range(0, 99) < 15) return corners[3'($urandom_range(0, 4))];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic req_type random_word();
      logic [3:0] known_ops [9];
      int unsigned r;
      req_type w;
      known_ops = '{OP_MOV, OP_OR, OP_AND, OP_XOR, OP_ADD, OP_SUB, OP_SHR, OP_SUBN, OP_SHL};
      r = $urandom_range(0, 99);
      w.mode = (r < 30) ? MODE_WRITE : (r < 40) ? MODE_READ : (r < 95) ? MODE_EXEC : 2'd3;
      w.reg_x = ($urandom_range(0, 9) == 0) ? FLAG_REG : 4'($urandom_range(0, 15));
      w.reg_y = ($urandom_range(0, 9) == 0) ? w.reg_x : 4'($urandom_range(0, 15));
      w.alu_op = ($urandom_range(0, 4) != 0) ? known_ops[4'($urandom_range(0, 8))]
                                             : 4'($urandom_range(0, 15));
      w.write_data = pick_byte();
      return w;
   endfunction

   initial begin
      tracker = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words: extremes, every operation, flag register as target.
      send_word(make_word(MODE_READ,  4'd7,  4'd0, OP_MOV,  8'h00));
      send_word(make_word(MODE_WRITE, 4'd0,  4'd0, OP_MOV,  8'hff));
      send_word(make_word(MODE_WRITE, 4'd1,  4'd0, OP_MOV,  8'h01));
      send_word(make_word(MODE_WRITE, 4'd2,  4'd0, OP_MOV,  8'h80));
      send_word(make_word(MODE_READ,  4'd0,  4'hf, 4'hf,    8'hff));
      send_word(make_word(MODE_EXEC,  4'd3,  4'd1, OP_ADD,  8'h00));
      send_word(make_word(MODE_EXEC,  4'd0,  4'd1, OP_ADD,  8'h00));
      send_word(make_word(MODE_EXEC,  4'd4,  4'd2, OP_SHL,  8'h00));
      send_word(make_word(MODE_EXEC,  4'd5,  4'd1, OP_SHR,  8'h00));
      send_word(make_word(MODE_EXEC,  4'd6,  4'd2, OP_MOV,  8'h00));
      send_word(make_word(MODE_EXEC,  4'd6,  4'd1, OP_OR,   8'h00));
      send_word(make_word(MODE_EXEC,  4'd6,  4'd2, OP_AND,  8'h00));
      send_word(make_word(MODE_EXEC,  4'd6,  4'd6, OP_XOR,  8'h00));
      send_word(make_word(MODE_EXEC,  4'd1,  4'd2, OP_SUB,  8'h00));
      send_word(make_word(MODE_EXEC,  4'd2,  4'd2, OP_SUB,  8'h00));
      send_word(make_word(MODE_EXEC,  4'd3,  4'd1, OP_SUBN, 8'h00));
      send_word(make_word(MODE_EXEC,  4'd1,  4'd3, OP_SUBN, 8'h00));
      send_word(make_word(MODE_WRITE, 4'hf,  4'd0, OP_MOV,  8'haa));
      send_word(make_word(MODE_EXEC,  4'hf,  4'd1, OP_MOV,  8'h00));
      send_word(make_word(MODE_EXEC,  4'hf,  4'd1, OP_ADD,  8'h00));
      send_word(make_word(MODE_EXEC,  4'hf,  4'hf, OP_SHL,  8'h00));
      send_word(make_word(MODE_EXEC,  4'd1,  4'd2, 4'h8,    8'h00));
      send_word(make_word(MODE_EXEC,  4'd1,  4'd2, 4'hf,    8'hff));
      send_word(make_word(2'd3,       4'd0,  4'hf, OP_SHL,  8'h55));
      send_word(make_word(MODE_READ,  4'hf,  4'd0, OP_MOV,  8'h00));

      // Random words; the tail runs with no gaps or stalls.
      for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS - CALM_WORDS) calm <= 1'b1;
         send_word(random_word());
      end
      req_valid <= 1'b0;

      // Drain owed results, then watch for strays.
      while (tracker.owed.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.errors == 0 && tracker.owed.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
